/* design/ppmd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppmd_pkg - shared types and constants for the PPM frame decoder
// Field widths, register indexes, channel count and the slot reset table.
// ---------------------------------------------------------------------------
package ppmd_pkg;

  localparam int NUM_CHANNELS = 8;   // 1 .. 8
  localparam int SLOT_W       = 4;   // slot position, NUM_CHANNELS means waiting for sync
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IDX_W        = 3;
  localparam int WIDTH_W      = 16;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 32;
  localparam int CFG_AW       = 2;

  localparam int IN_TDATA_W   = 40;  // edge_time, read_index, pad
  localparam int IN_TUSER_W   = 1;   // op
  localparam int OUT_TDATA_W  = 56;  // flags, index, value, sync count, pad

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_FRAME_GAP     = 2'd0,
    REG_MIN_CHANNEL_WIDTH = 2'd1,
    REG_MAX_CHANNEL_WIDTH = 2'd2
  } cfg_reg_e;

  localparam logic [WIDTH_W-1:0] RST_MIN_FRAME_GAP     = 16'd3000;
  localparam logic [WIDTH_W-1:0] RST_MIN_CHANNEL_WIDTH = 16'd900;
  localparam logic [WIDTH_W-1:0] RST_MAX_CHANNEL_WIDTH = 16'd2100;

  // write request into the channel store
  typedef struct packed {
    logic               en;
    logic [CH_AW-1:0]   addr;
    logic [WIDTH_W-1:0] data;
  } mem_wr_t;

  // per-edge result from the timing logic
  typedef struct packed {
    logic               stored;
    logic               resynced;
    logic               frame_started;
    logic [IDX_W-1:0]   chan_index;
    logic [WIDTH_W-1:0] chan_value;
    logic [CNT_W-1:0]   sync_count;
  } edge_res_t;

  // value a slot holds before its first write
  function automatic logic [WIDTH_W-1:0] slot_reset_val(input logic [CH_AW-1:0] idx);
    logic [WIDTH_W-1:0] v;
    v = '0;
    case (SLOT_W'(idx))
      4'd0:    v = 16'd1500;
      4'd1:    v = 16'd1500;
      4'd2:    v = 16'd1000;
      4'd3:    v = 16'd1500;
      4'd4:    v = 16'd2000;
      4'd5:    v = 16'd1000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/ppm_frame_decoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppm_frame_decoder - PPM radio stream decoder
// Edge beats update sync state and the channel store; read beats return a slot.
// ---------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat per input beat, in the
// next cycle, in order. Edge timing, bounds checks and the store write are
// done in the cycle the beat is accepted; a read beat uses the channel RAM's
// registered read port, loaded together with the output register. The output
// register takes a new beat in the same cycle its waiting result is taken, so
// throughput stays one beat per cycle unless the sink stalls; while a result
// waits on the sink, the input is held off. Slots read as their reset-table
// values until first written after reset; no clearing pass is needed.
// ---------------------------------------------------------------------------
module ppm_frame_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ppmd_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [ppmd_pkg::WIDTH_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ppmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // edge_time[31:0], read_index[34:32]
  input  logic [ppmd_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,  // op[0]
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // stored[0], resynced[1], frame_started[2], chan_index[5:3], chan_value[21:6],
  // sync_count[53:22]
  output logic [ppmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  logic                            in_fire;
  logic                            is_read;
  logic [ppmd_pkg::TIME_W-1:0]     edge_time;
  logic [ppmd_pkg::IDX_W-1:0]      read_index;

  ppmd_pkg::edge_res_t             res;
  ppmd_pkg::edge_res_t             res_out;
  ppmd_pkg::mem_wr_t               wr;
  logic [ppmd_pkg::WIDTH_W-1:0]    rd_data;

  logic                            out_valid_q, out_valid_d;
  ppmd_pkg::edge_res_t             out_q;
  logic                            out_read_q;
  logic [ppmd_pkg::WIDTH_W-1:0]    out_value;

  assign edge_time  = s_axis_tdata_i[ppmd_pkg::TIME_W-1:0];
  assign read_index = s_axis_tdata_i[ppmd_pkg::TIME_W +: ppmd_pkg::IDX_W];
  assign is_read    = s_axis_tuser_i[0] == ppmd_pkg::OP_READ;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  ppmd_edge_ctrl u_edge_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire && !is_read),
    .edge_time_i (edge_time),
    .res_o       (res),
    .wr_o        (wr)
  );

  ppmd_chan_mem u_chan_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_en_i   (in_fire && is_read),
    .rd_idx_i  (read_index),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // a read beat reports the slot it asked for
  always_comb begin
    res_out = res;
    if (is_read) begin
      res_out.chan_index = read_index;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q      <= res_out;
      out_read_q <= is_read;
    end
  end

  // read data stays put in the RAM read register until the next read beat
  assign out_value = out_read_q ? rd_data : out_q.chan_value;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.sync_count, out_value, out_q.chan_index,
                            out_q.frame_started, out_q.resynced, out_q.stored};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_read_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_read_q |-> !out_q.stored && !out_q.resynced && !out_q.frame_started)
    else $error("read beat carries edge flags");

  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

/* design/ppmd_chan_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppmd_chan_mem - channel width store
// Synchronous RAM, one write and one registered read per cycle. A valid bit
// per slot stands in for the reset table until the slot is first written.
// ---------------------------------------------------------------------------
module ppmd_chan_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppmd_pkg::mem_wr_t              wr_i,
  input  logic                           rd_en_i,
  input  logic [ppmd_pkg::IDX_W-1:0]     rd_idx_i,
  output logic [ppmd_pkg::WIDTH_W-1:0]   rd_data_o
);

  logic [ppmd_pkg::WIDTH_W-1:0]      mem_q [ppmd_pkg::NUM_CHANNELS];
  logic [ppmd_pkg::NUM_CHANNELS-1:0] valid_q;

  logic [ppmd_pkg::SLOT_W-1:0]  rd_idx_ext;
  logic                         rd_in_range;
  logic [ppmd_pkg::CH_AW-1:0]   rd_addr;

  logic [ppmd_pkg::WIDTH_W-1:0] rdata_q;
  logic [ppmd_pkg::CH_AW-1:0]   rd_addr_q;
  logic                         rd_valid_q;
  logic                         rd_range_q;

  assign rd_idx_ext  = ppmd_pkg::SLOT_W'(rd_idx_i);
  assign rd_in_range = rd_idx_ext < ppmd_pkg::SLOT_W'(ppmd_pkg::NUM_CHANNELS);
  assign rd_addr     = rd_idx_ext[ppmd_pkg::CH_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // read port: data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i && rd_in_range) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (rd_en_i) begin
      rd_addr_q  <= rd_addr;
      rd_valid_q <= rd_in_range && valid_q[rd_addr];
      rd_range_q <= rd_in_range;
    end
  end

  always_comb begin
    if (!rd_range_q) begin
      rd_data_o = '0;
    end else if (rd_valid_q) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = ppmd_pkg::slot_reset_val(rd_addr_q);
    end
  end

endmodule

/* design/ppmd_edge_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppmd_edge_ctrl - edge timing and sync tracking
// Measures the width since the last edge, checks it against the frame gap or
// the channel bounds, steps the slot position and counts resyncs.
// ---------------------------------------------------------------------------
module ppmd_edge_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppmd_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [ppmd_pkg::WIDTH_W-1:0]    cfg_wdata_i,
  input  logic                            fire_i,
  input  logic [ppmd_pkg::TIME_W-1:0]     edge_time_i,
  output ppmd_pkg::edge_res_t             res_o,
  output ppmd_pkg::mem_wr_t               wr_o
);

  logic [ppmd_pkg::WIDTH_W-1:0] min_gap_q, min_w_q, max_w_q;
  logic [ppmd_pkg::TIME_W-1:0]  last_q, last_d;
  logic [ppmd_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [ppmd_pkg::CNT_W-1:0]   sync_q, sync_d;

  logic [ppmd_pkg::TIME_W-1:0]  width;
  logic                         waiting;
  logic                         in_bounds;
  logic                         do_store, do_resync, do_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= ppmd_pkg::RST_MIN_FRAME_GAP;
      min_w_q   <= ppmd_pkg::RST_MIN_CHANNEL_WIDTH;
      max_w_q   <= ppmd_pkg::RST_MAX_CHANNEL_WIDTH;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ppmd_pkg::REG_MIN_FRAME_GAP:     min_gap_q <= cfg_wdata_i;
        ppmd_pkg::REG_MIN_CHANNEL_WIDTH: min_w_q   <= cfg_wdata_i;
        ppmd_pkg::REG_MAX_CHANNEL_WIDTH: max_w_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign width     = edge_time_i - last_q;
  assign waiting   = slot_q >= ppmd_pkg::SLOT_W'(ppmd_pkg::NUM_CHANNELS);
  assign in_bounds = (width <= ppmd_pkg::TIME_W'(max_w_q)) &&
                     (width >= ppmd_pkg::TIME_W'(min_w_q));

  assign do_start  = fire_i && waiting && (width >= ppmd_pkg::TIME_W'(min_gap_q));
  assign do_resync = fire_i && (waiting ? (width < ppmd_pkg::TIME_W'(min_gap_q))
                                        : !in_bounds);
  assign do_store  = fire_i && !waiting && in_bounds;

  always_comb begin
    last_d = fire_i ? edge_time_i : last_q;
    sync_d = do_resync ? sync_q + 1'b1 : sync_q;
    slot_d = slot_q;
    if (do_resync) begin
      slot_d = ppmd_pkg::SLOT_W'(ppmd_pkg::NUM_CHANNELS);
    end else if (do_start) begin
      slot_d = '0;
    end else if (do_store) begin
      slot_d = slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      slot_q <= '0;
      sync_q <= '0;
    end else begin
      last_q <= last_d;
      slot_q <= slot_d;
      sync_q <= sync_d;
    end
  end

  always_comb begin
    res_o.stored        = do_store;
    res_o.resynced      = do_resync;
    res_o.frame_started = do_start;
    res_o.chan_index    = do_store ? slot_q[ppmd_pkg::IDX_W-1:0] : '0;
    res_o.chan_value    = do_store ? width[ppmd_pkg::WIDTH_W-1:0] : '0;
    res_o.sync_count    = sync_d;
    wr_o.en             = do_store;
    wr_o.addr           = slot_q[ppmd_pkg::CH_AW-1:0];
    wr_o.data           = width[ppmd_pkg::WIDTH_W-1:0];
  end

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({do_store, do_resync, do_start}) && (fire_i == (do_store || do_resync || do_start)))
    else $error("edge must have exactly one outcome");

  a_resync_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_resync |=> (sync_q == $past(sync_q) + 1'b1) &&
                  (slot_q == ppmd_pkg::SLOT_W'(ppmd_pkg::NUM_CHANNELS)))
    else $error("resync did not bump count or drop to waiting");

  a_store_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_store |=> slot_q == $past(slot_q) + 1'b1)
    else $error("slot did not advance after store");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(last_q) && $stable(slot_q) && $stable(sync_q))
    else $error("timing state moved without an edge");

endmodule
